FILE: design/bitmap_index_allocator_macros.svh
// Assertion macros shared by the checkers of the bitmap index allocator.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and switched off while reset is asserted.
`ifndef BITMAP_INDEX_ALLOCATOR_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bia_pkg.sv
`timescale 1ns / 1ps

package bia_pkg;

    localparam int KIND_W     = 2;
    localparam int SLOT_W     = 12;
    localparam int VALUE_W    = 13;
    localparam int WORD_BITS  = 64;
    localparam int BIT_W      = 6;

    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } bia_state_t;

    // Result of the lowest-free-bit search over one bitmap word.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } bia_find_t;

endpackage

FILE: design/bia_find_free.sv
`timescale 1ns / 1ps

module bia_find_free (
    input  logic [bia_pkg::WORD_BITS-1:0] word,
    output bia_pkg::bia_find_t            result
);
    import bia_pkg::*;

    localparam int GROUPS  = 8;
    localparam int GROUP_W = 8;

    logic [GROUPS-1:0]  grp_free;
    logic [2:0]         grp_sel;
    logic [GROUP_W-1:0] grp_bits;
    logic [2:0]         bit_sel;

    // Two short priority searches: first the lowest byte with a free bit,
    // then the lowest free bit inside that byte.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_free[g] = ~&word[g*GROUP_W +: GROUP_W];
        end
        grp_sel = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_free[g])
            begin
                grp_sel = 3'(g);
            end
        end
    end

    always_comb
    begin
        grp_bits = word[{grp_sel, 3'b000} +: GROUP_W];
        bit_sel  = '0;
        for (int b = GROUP_W - 1; b >= 0; b--)
        begin
            if (!grp_bits[b])
            begin
                bit_sel = 3'(b);
            end
        end
    end

    assign result.found = |grp_free;
    assign result.idx   = {grp_sel, bit_sel};

endmodule

FILE: design/bitmap_index_allocator.sv
// Bitmap index allocator. Each transaction is offered on kind, slot and
// want_used together with start, and is taken at a rising edge where start
// is high and busy is low; the block then works on that one transaction
// alone and raises busy until it is done. A transaction marks one index used
// or free, tests one index, allocates the lowest free index of the first word
// with room (searching from the word of the last allocated index and wrapping
// round), or returns the number of used or free indexes. Exactly one result
// comes back per transaction: value and flag are valid for the single cycle
// in which done is high, and the receiver cannot stall them, so it must take
// them in that cycle. The bitmap lives in a synchronous memory of NUM_WORDS
// words of 64 bits with a registered read port and one write port. Mark, test
// and count read the addressed word when they are accepted; the execute state
// then registers the result for the done strobe and, for a mark that changes
// the bit, writes the word back. Allocation reads one word after another until
// a free bit is found, at most NUM_WORDS words; a full bitmap reads every word
// and returns flag 0. The next transaction may be offered in the cycle of the
// done strobe. After reset the block sweeps the memory to all free, one word
// per cycle, and keeps busy high until the sweep is done.
`timescale 1ns / 1ps

module bitmap_index_allocator #(
    parameter int NUM_WORDS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bia_pkg::KIND_W-1:0]   kind,
    input  logic [bia_pkg::SLOT_W-1:0]   slot,
    input  logic                         want_used,
    output logic                         done,
    output logic [bia_pkg::VALUE_W-1:0]  value,
    output logic                         flag
);
    import bia_pkg::*;

    // Word address width, index (rover) width, scan count width and the
    // width of the used-index total.
    localparam int WW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int RW    = WW + BIT_W;
    localparam int CW    = $clog2(NUM_WORDS + 1);
    localparam int TOTAL = NUM_WORDS * WORD_BITS;
    localparam int TW    = $clog2(TOTAL + 1);

    localparam logic [WW-1:0] LAST_WORD = WW'(NUM_WORDS - 1);
    localparam logic [CW-1:0] SCAN_ALL  = CW'(NUM_WORDS);
    localparam logic [TW-1:0] TOTAL_T   = TW'(TOTAL);

    // The bitmap memory: one bit per index, 1 means used.
    logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic                 mem_we;
    logic [WW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WW-1:0]        mem_raddr;

    // Control state.
    bia_state_t state_reg, state_next;
    logic [WW-1:0] clr_reg, clr_next;
    logic [RW-1:0] rover_reg, rover_next;
    logic [TW-1:0] used_reg, used_next;
    logic          done_reg, done_next;

    // Transaction and scan registers.
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               want_reg, want_next;
    logic               in_range_reg, in_range_next;
    logic [WW-1:0]      addr_reg, addr_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               flag_reg, flag_next;

    logic [BIT_W-1:0]     slot_word;
    logic                 slot_in_range;
    logic                 cur_bit;
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_BITS-1:0] alloc_mask;
    logic [WW-1:0]        scan_wrap;
    logic [RW-1:0]        found_index;
    bia_find_t            find;

    bia_find_free u_find (
        .word   (rdata_reg),
        .result (find)
    );

    assign slot_word     = slot[SLOT_W-1:BIT_W];
    assign slot_in_range = int'(slot_word) < NUM_WORDS;
    assign cur_bit       = rdata_reg[bit_reg];
    assign mark_mask     = WORD_BITS'(1) << bit_reg;
    assign alloc_mask    = WORD_BITS'(1) << find.idx;
    assign scan_wrap     = (addr_reg == LAST_WORD) ? '0 : addr_reg + WW'(1);
    assign found_index   = {addr_reg, find.idx};

    // Memory with a registered read port and one write port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= bitmap_mem[mem_raddr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == KIND_ALLOC) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (find.found || cnt_reg == SCAN_ALL)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control for each state.
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = rdata_reg;
        mem_raddr     = addr_reg;
        clr_next      = clr_reg;
        rover_next    = rover_reg;
        used_next     = used_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        bit_next      = bit_reg;
        want_next     = want_reg;
        in_range_next = in_range_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        value_next    = value_reg;
        flag_next     = flag_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + WW'(1);
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next     = kind;
                    bit_next      = slot[BIT_W-1:0];
                    want_next     = want_used;
                    in_range_next = slot_in_range;
                    if (kind == KIND_ALLOC)
                    begin
                        addr_next = rover_reg[RW-1:BIT_W];
                        cnt_next  = CW'(1);
                    end
                    else
                    begin
                        addr_next = WW'(slot_word);
                    end
                    mem_raddr = addr_next;
                end
            end
            ST_EXEC:
            begin
                done_next  = 1'b1;
                value_next = '0;
                flag_next  = 1'b0;
                case (kind_reg)
                    KIND_MARK:
                    begin
                        if (in_range_reg && cur_bit != want_reg)
                        begin
                            mem_we = 1'b1;
                            if (want_reg)
                            begin
                                mem_wdata = rdata_reg | mark_mask;
                                used_next = used_reg + TW'(1);
                            end
                            else
                            begin
                                mem_wdata = rdata_reg & ~mark_mask;
                                used_next = used_reg - TW'(1);
                            end
                        end
                    end
                    KIND_TEST:
                    begin
                        flag_next = in_range_reg && (cur_bit == want_reg);
                    end
                    KIND_COUNT:
                    begin
                        value_next = want_reg ? VALUE_W'(used_reg)
                                              : VALUE_W'(TOTAL_T - used_reg);
                    end
                    default:
                    begin
                        value_next = '0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (find.found)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = rdata_reg | alloc_mask;
                    rover_next = found_index;
                    used_next  = used_reg + TW'(1);
                    done_next  = 1'b1;
                    value_next = VALUE_W'(found_index);
                    flag_next  = 1'b1;
                end
                else if (cnt_reg == SCAN_ALL)
                begin
                    done_next  = 1'b1;
                    value_next = '0;
                    flag_next  = 1'b0;
                end
                else
                begin
                    addr_next = scan_wrap;
                    mem_raddr = scan_wrap;
                    cnt_next  = cnt_reg + CW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            rover_reg <= '0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rover_reg <= rover_next;
            used_reg  <= used_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        bit_reg      <= bit_next;
        want_reg     <= want_next;
        in_range_reg <= in_range_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        value_reg    <= value_next;
        flag_reg     <= flag_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign value = value_reg;
    assign flag  = flag_reg;

endmodule

FILE: design/bia_checker.sv
`timescale 1ns / 1ps
`include "bitmap_index_allocator_macros.svh"

module bia_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result only appears once the block has dropped back to idle.
    `BIA_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "result while still busy")

    // Every accepted transaction keeps the block busy in the following cycle.
    `BIA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted but not busy")

    // Results are single-cycle strobes; no two arrive back to back.
    `BIA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held for two cycles")

    // A result is always preceded by a cycle of work.
    `BIA_ASSERT_SAME(a_done_after_work, clk, rst_n, done, $past(busy), "result without work")

endmodule

bind bitmap_index_allocator bia_checker u_bia_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

FILE: bench/index_allocator_checker.sv
`timescale 1ns / 1ps

module index_allocator_checker #(
    parameter int NUM_WORDS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [bia_pkg::KIND_W-1:0]   kind,
    input  logic [bia_pkg::SLOT_W-1:0]   slot,
    input  logic                         want_used,
    input  logic                         done,
    input  logic [bia_pkg::VALUE_W-1:0]  value,
    input  logic                         flag,
    output int                           fail_count,
    output int                           outstanding,
    output int                           results_seen
);
    import bia_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               flag;
    } alloc_result_t;

    // Shadow copy of the allocator state.
    logic [WORD_BITS-1:0] usage_map [NUM_WORDS];
    logic [SLOT_W-1:0]    last_index;
    logic [VALUE_W-1:0]   used_count;

    alloc_result_t expected_results [$];
    alloc_result_t oldest;
    alloc_result_t predicted;

    task automatic set_usage(input int w, input int b, input logic used);
        if (usage_map[w][b] != used)
        begin
            usage_map[w][b] = used;
            if (used)
                used_count = used_count + VALUE_W'(1);
            else
                used_count = used_count - VALUE_W'(1);
        end
    endtask

    task automatic predict_request(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                                   input logic w, output alloc_result_t r);
        int word;
        int bit_pos;
        int first_word;
        int cand;
        int low;
        logic [WORD_BITS-1:0] free_bits;
        logic hit;

        word = int'(s >> BIT_W);
        bit_pos = int'(s[BIT_W-1:0]);
        r.kind = k;
        r.slot = s;
        r.value = '0;
        r.flag = 1'b0;
        hit = 1'b0;
        if (k == KIND_MARK)
        begin
            if (word < NUM_WORDS)
                set_usage(word, bit_pos, w);
        end
        else if (k == KIND_TEST)
        begin
            if (word < NUM_WORDS)
                r.flag = (usage_map[word][bit_pos] == w);
        end
        else if (k == KIND_ALLOC)
        begin
            // Next fit: begin at the word of the last assigned index and wrap.
            first_word = int'(last_index >> BIT_W) % NUM_WORDS;
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                cand = (first_word + i) % NUM_WORDS;
                free_bits = ~usage_map[cand];
                if (!hit && free_bits != '0)
                begin
                    low = 0;
                    for (int b = WORD_BITS - 1; b >= 0; b--)
                    begin
                        if (free_bits[b])
                            low = b;
                    end
                    set_usage(cand, low, 1'b1);
                    last_index = SLOT_W'(cand * WORD_BITS + low);
                    r.value = VALUE_W'(cand * WORD_BITS + low);
                    r.flag = 1'b1;
                    hit = 1'b1;
                end
            end
        end
        else
        begin
            if (w)
                r.value = used_count;
            else
                r.value = VALUE_W'(NUM_WORDS * WORD_BITS - int'(used_count));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
                usage_map[i] = '0;
            last_index = '0;
            used_count = '0;
            expected_results.delete();
            fail_count = 0;
            outstanding = 0;
            results_seen = 0;
        end
        else
        begin
            // A result strobed in this cycle belongs to an earlier transaction,
            // so it is checked before any transaction accepted at this edge.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display("[%0t] result with nothing pending: value %0d flag %0d",
                                 $realtime, value, flag);
                    fail_count++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    results_seen++;
                    if (value !== oldest.value || flag !== oldest.flag)
                    begin
                        if (fail_count < REPORT_LIMIT)
                            $display({"[%0t] kind %0d slot %0d: expected value %0d ",
                                      "flag %0d, got value %0d flag %0d"},
                                     $realtime, oldest.kind, oldest.slot, oldest.value,
                                     oldest.flag, value, flag);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                predict_request(kind, slot, want_used, predicted);
                expected_results.push_back(predicted);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bia_pkg::*;

    localparam int NUM_WORDS = 64;
    localparam int INDEX_COUNT = NUM_WORDS * WORD_BITS;
    // The longest correct wait between two transactions is a full-bitmap
    // allocation, the clearing sweep after reset, or a long run of sender idle
    // cycles. The limit is several times all of those.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles allowed after the last result before the verdict.
    localparam int TAIL_CYCLES = NUM_WORDS + 6;
    localparam int RANDOM_PER_PHASE = 250;
    // A run of allocations that packs the lowest words and carries the rover
    // across several word boundaries.
    localparam int FILL_ALLOCS = 200;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [KIND_W-1:0]  kind = KIND_MARK;
    logic [SLOT_W-1:0]  slot = '0;
    logic               want_used = 1'b0;
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] value;
    logic               flag;

    int fail_count;
    int outstanding;
    int results_seen;
    int requests_sent = 0;
    int quiet_cycles = 0;
    // Percentage of cycles in which the sender holds back before a transaction.
    int idle_pct = 0;

    always #5 clk = ~clk;

    bitmap_index_allocator #(
        .NUM_WORDS(NUM_WORDS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .slot(slot),
        .want_used(want_used),
        .done(done),
        .value(value),
        .flag(flag)
    );

    index_allocator_checker #(
        .NUM_WORDS(NUM_WORDS)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .slot(slot),
        .want_used(want_used),
        .done(done),
        .value(value),
        .flag(flag),
        .fail_count(fail_count),
        .outstanding(outstanding),
        .results_seen(results_seen)
    );

    // The watchdog is cleared by any accepted transaction or any result, and
    // ends the run if the block stays silent for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one transaction at a falling edge, after a random number of idle
    // cycles, and holds it until a rising edge finds busy low. Reading busy
    // right after the edge gives the value the block itself sampled.
    task automatic send_request(input logic [KIND_W-1:0] k, input logic [SLOT_W-1:0] s,
                                input logic w);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        kind <= k;
        slot <= s;
        want_used <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stops offering work until every expected result has come back. The
    // count is read at falling edges, well away from the checker's update.
    task automatic wait_until_drained();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // One pacing phase of random traffic. Most of it is single transactions
    // of every kind with random fields; a quarter is a short sequence that
    // frees an index, checks that it reads free, and allocates, which drives
    // the next-fit search into holes left behind the rover.
    task automatic random_phase(input int pct, input int count);
        int n;
        int pick;
        logic [SLOT_W-1:0] hole;

        idle_pct = pct;
        wait_until_drained();
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(99) < 25)
            begin
                hole = SLOT_W'($urandom_range(INDEX_COUNT - 1));
                send_request(KIND_MARK, hole, 1'b0);
                send_request(KIND_TEST, hole, 1'b0);
                send_request(KIND_ALLOC, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                             1'($urandom_range(1)));
                n += 3;
            end
            else
            begin
                pick = int'($urandom_range(99));
                if (pick < 35)
                    send_request(KIND_MARK, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                                 1'($urandom_range(1)));
                else if (pick < 60)
                    send_request(KIND_TEST, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                                 1'($urandom_range(1)));
                else if (pick < 90)
                    send_request(KIND_ALLOC, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                                 1'($urandom_range(1)));
                else
                    send_request(KIND_COUNT, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                                 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed corners on an empty bitmap. The block is still sweeping its
        // memory at this point and holds the first transaction off with busy.
        idle_pct = 0;
        send_request(KIND_COUNT, 12'd0, 1'b1);
        send_request(KIND_COUNT, 12'hFFF, 1'b0);
        send_request(KIND_TEST, 12'd0, 1'b0);
        send_request(KIND_TEST, 12'd0, 1'b1);
        send_request(KIND_ALLOC, 12'hFFF, 1'b0);
        send_request(KIND_ALLOC, 12'd0, 1'b1);
        send_request(KIND_MARK, 12'hFFF, 1'b1);
        send_request(KIND_TEST, 12'hFFF, 1'b1);
        // Marking an index to the value it already holds changes nothing.
        send_request(KIND_MARK, 12'hFFF, 1'b1);
        send_request(KIND_COUNT, 12'd0, 1'b1);
        send_request(KIND_MARK, 12'hFFF, 1'b0);
        send_request(KIND_MARK, 12'hFFF, 1'b0);
        send_request(KIND_COUNT, 12'hAAA, 1'b1);
        // Freeing index zero lets the next allocation take it again.
        send_request(KIND_MARK, 12'd0, 1'b0);
        send_request(KIND_ALLOC, 12'h555, 1'b0);
        send_request(KIND_TEST, 12'd0, 1'b1);
        send_request(KIND_MARK, 12'hAAA, 1'b1);
        send_request(KIND_MARK, 12'h555, 1'b1);
        send_request(KIND_TEST, 12'hAAA, 1'b0);
        send_request(KIND_TEST, 12'h555, 1'b1);
        send_request(KIND_ALLOC, 12'd0, 1'b0);
        send_request(KIND_COUNT, 12'd0, 1'b0);

        // A long run of allocations fills whole words, so the search has to
        // skip full words and wrap its start forward. Counts follow.
        wait_until_drained();
        for (int i = 0; i < FILL_ALLOCS; i++)
            send_request(KIND_ALLOC, SLOT_W'($urandom_range(INDEX_COUNT - 1)),
                         1'($urandom_range(1)));
        send_request(KIND_COUNT, 12'd0, 1'b1);
        send_request(KIND_COUNT, 12'd0, 1'b0);
        send_request(KIND_TEST, 12'hFFF, 1'b1);

        // Random traffic under several sender paces. The receiver side has
        // no stall to apply.
        random_phase(0, RANDOM_PER_PHASE);
        random_phase(62, RANDOM_PER_PHASE);
        random_phase(0, RANDOM_PER_PHASE);
        random_phase(35, RANDOM_PER_PHASE);

        // Let every pending result arrive, then allow a full allocation's
        // worth of extra cycles for anything stray.
        wait_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("Sent %0d transactions: directed corners, a run of allocations,",
                 requests_sent);
        $display("and four random pacing phases; %0d results compared, %0d failures.",
                 results_seen, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/bia_pkg.sv
design/bia_find_free.sv
design/bitmap_index_allocator.sv
design/bia_checker.sv
bench/index_allocator_checker.sv
bench/testbench.sv
